/* hdl/modexp_pkg.sv */
// Shared constants for the modular exponentiation block.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package modexp_pkg;

   // Width of every request and response data port.
   localparam int FIELD_BITS = 32;

   // Default internal operand width; operands are taken at this many low bits.
   localparam int DEFAULT_WORD_BITS = 32;

endpackage : modexp_pkg

`default_nettype wire

/* hdl/modexp_mulmod.sv */
// Shared modular multiplier: (a * b) mod m by MSB-first shift-and-add.
// Depends on modexp_pkg for the default operand width.
`default_nettype none

module modexp_mulmod #(
   parameter int WORD_BITS = modexp_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire logic [WORD_BITS-1:0] op_a,
   input  wire logic [WORD_BITS-1:0] op_b,
   input  wire logic [WORD_BITS-1:0] op_m,
   output      logic                 done,
   output      logic [WORD_BITS-1:0] product
);
   import modexp_pkg::*;

   localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(WORD_BITS - 1);

   logic                 run_ff, run_in;
   logic                 phase_ff, phase_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;

   // One modular adder, shared by the doubling and the add phases.
   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS-1:0] gap;
   logic [WORD_BITS-1:0] sum;
   logic                 apply;

   always_comb begin
      addend = phase_ff ? a_ff : acc_ff;
      gap    = op_m - addend;
      sum    = (acc_ff >= gap) ? (acc_ff - gap) : (acc_ff + addend);
      apply  = !phase_ff || b_ff[WORD_BITS-1];
   end

   always_comb begin
      run_in   = run_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (go) begin
         run_in   = 1'b1;
         phase_in = 1'b0;
         cnt_in   = LAST_BIT;
         a_in     = op_a;
         b_in     = op_b;
         acc_in   = '0;
      end else if (run_ff) begin
         if (apply) begin
            acc_in = sum;
         end
         if (!phase_ff) begin
            phase_in = 1'b1;
         end else begin
            // Advance to the next multiplier bit.
            phase_in = 1'b0;
            b_in     = b_ff << 1;
            if (cnt_ff == '0) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule : modexp_mulmod

`default_nettype wire

/* hdl/modular_exponentiation.sv */
// Top level of the modular exponentiation block: sequencer around one multiplier.
// Depends on modexp_pkg and modexp_mulmod.
`default_nettype none

// Computes base^power mod modulus by right-to-left square-and-multiply.
// A request is taken on a clock edge with start high and busy low; the
// response appears on rsp_* for exactly one cycle with rsp_valid high and
// cannot be held off, so capture it when it shows. busy stays high while a
// request is being worked and drops in the cycle the response appears, so a
// new request may be issued in that same cycle. All work runs through one
// shared modular multiplier that handles each operand bit in a doubling phase
// and an add phase and then raises done; the next product is issued only once
// the last is done. A request costs P products: one to reduce the base, one
// squaring per exponent bit below the top set bit, and one multiply per set
// bit, so P = n + (set bits) for an exponent whose top set bit is bit n-1, and
// P = 1 for a zero exponent. A zero modulus (flagged by rsp_bad_modulus,
// residue 0) and a modulus of one (residue 0) respond in the cycle after the
// request is taken.
module modular_exponentiation #(
   parameter int WORD_BITS = modexp_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic [modexp_pkg::FIELD_BITS-1:0] req_base_value,
   input  wire logic [modexp_pkg::FIELD_BITS-1:0] req_power,
   input  wire logic [modexp_pkg::FIELD_BITS-1:0] req_modulus_value,
   output      logic                              rsp_valid,
   output      logic [modexp_pkg::FIELD_BITS-1:0] rsp_residue,
   output      logic                              rsp_bad_modulus
);
   import modexp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_MUL    = 4'b0100,
      ST_SQR    = 4'b1000
   } state_type;

   localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

   state_type             state_ff, state_in;
   logic [WORD_BITS-1:0]  m_ff, m_in;
   logic [WORD_BITS-1:0]  e_ff, e_in;
   logic [WORD_BITS-1:0]  acc_ff, acc_in;
   logic [WORD_BITS-1:0]  sq_ff, sq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_residue_ff, rsp_residue_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   // Operands as seen at the internal width: drop or zero-fill upper bits.
   logic [WORD_BITS-1:0]  op_base;
   logic [WORD_BITS-1:0]  op_power;
   logic [WORD_BITS-1:0]  op_mod;

   assign op_base  = WORD_BITS'(req_base_value);
   assign op_power = WORD_BITS'(req_power);
   assign op_mod   = WORD_BITS'(req_modulus_value);

   // Multiplier command and status.
   logic                  mm_go;
   logic [WORD_BITS-1:0]  mm_a;
   logic [WORD_BITS-1:0]  mm_b;
   logic                  mm_done;
   logic [WORD_BITS-1:0]  mm_product;

   // Exponent step decision, taken on the new square value as it is loaded.
   logic                  step;
   logic [WORD_BITS-1:0]  step_sq;

   always_comb begin
      state_in       = state_ff;
      m_in           = m_ff;
      e_in           = e_ff;
      acc_in         = acc_ff;
      sq_in          = sq_ff;
      rsp_valid_in   = 1'b0;
      rsp_residue_in = rsp_residue_ff;
      rsp_bad_in     = rsp_bad_ff;
      mm_go          = 1'b0;
      mm_a           = acc_ff;
      mm_b           = sq_ff;
      step           = 1'b0;
      step_sq        = sq_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (start) begin
               m_in = op_mod;
               e_in = op_power;
               if (op_mod == '0) begin
                  // Zero modulus: flag it and answer right away.
                  rsp_valid_in   = 1'b1;
                  rsp_residue_in = '0;
                  rsp_bad_in     = 1'b1;
               end else if (op_mod == ONE) begin
                  // Everything is zero modulo one.
                  rsp_valid_in   = 1'b1;
                  rsp_residue_in = '0;
                  rsp_bad_in     = 1'b0;
               end else begin
                  // Reduce the base as 1 * base mod m.
                  acc_in   = ONE;
                  mm_go    = 1'b1;
                  mm_a     = ONE;
                  mm_b     = op_base;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE, ST_SQR: begin
            if (mm_done) begin
               sq_in   = mm_product;
               step    = 1'b1;
               step_sq = mm_product;
            end
         end
         ST_MUL: begin
            if (mm_done) begin
               acc_in = mm_product;
               if ((e_ff >> 1) == '0) begin
                  // No set bits left: drop the final squaring.
                  rsp_valid_in   = 1'b1;
                  rsp_residue_in = FIELD_BITS'(mm_product);
                  rsp_bad_in     = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  e_in     = e_ff >> 1;
                  mm_go    = 1'b1;
                  mm_a     = sq_ff;
                  mm_b     = sq_ff;
                  state_in = ST_SQR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (step) begin
         if (e_ff == '0) begin
            rsp_valid_in   = 1'b1;
            rsp_residue_in = FIELD_BITS'(acc_ff);
            rsp_bad_in     = 1'b0;
            state_in       = ST_IDLE;
         end else if (e_ff[0]) begin
            mm_go    = 1'b1;
            mm_a     = acc_ff;
            mm_b     = step_sq;
            state_in = ST_MUL;
         end else begin
            e_in     = e_ff >> 1;
            mm_go    = 1'b1;
            mm_a     = step_sq;
            mm_b     = step_sq;
            state_in = ST_SQR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff           <= m_in;
      e_ff           <= e_in;
      acc_ff         <= acc_in;
      sq_ff          <= sq_in;
      rsp_residue_ff <= rsp_residue_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   modexp_mulmod #(
      .WORD_BITS (WORD_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .go      (mm_go),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .op_m    (m_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_residue     = rsp_residue_ff;
   assign rsp_bad_modulus = rsp_bad_ff;

endmodule : modular_exponentiation

`default_nettype wire

/* hdl/modexp_checker.sv */
// Port-level checks for the modular exponentiation block, bound to its top.
// Depends on modexp_pkg and on the top level modular_exponentiation.
`default_nettype none

module modexp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic [modexp_pkg::FIELD_BITS-1:0] rsp_residue,
   input wire logic                              rsp_bad_modulus
);
   import modexp_pkg::*;

   // A flagged modulus always comes with a zero residue.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_modulus) |-> (rsp_residue == '0))
      else $error("bad modulus response with nonzero residue");

   // A response never overlaps a request in flight.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // Every accepted request either answers at once or goes busy.
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("request accepted but neither busy nor answered");

   // Busy only ends with a response.
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // Reset leaves the block idle and quiet.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("not idle after reset");

endmodule : modexp_checker

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

`default_nettype wire
